>>> src/dclgp_pkg.sv
// Package for the two-channel lock-in gain/phase meter.
// Holds shared constants, the CORDIC arctangent table and the queue entry type.
package dclgp_pkg;

    localparam int MAX_SAMPLES_DEF     = 16384;
    localparam int SAMPLE_BITS         = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int ROT_STEPS = 20;
    localparam int VEC_STEPS = 24;
    localparam int SINE_SEED = 5093851;
    localparam int DEG128_PER_TURN = 46080;
    localparam int SUM_W = 48;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SPAN  = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic [0:0] CFG_PHASE_STEP = 1'b0;
    localparam logic [0:0] CFG_THRESHOLD  = 1'b1;

    // Closed record handed from the front part to the back part.
    typedef struct packed {
        logic [SUM_W-1:0] s0;
        logic [SUM_W-1:0] s1;
        logic [SUM_W-1:0] s2;
        logic [SUM_W-1:0] s3;
        logic             span_low;
    } rec_t;

    typedef enum logic [2:0] {
        FR_IDLE, FR_ROT, FR_MIX, FR_PROD, FR_ACC
    } fr_state_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_VEC, BK_DIV, BK_FRAC, BK_OUT
    } bk_state_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10680862;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> src/dclgp_front.sv
// Front part: reference generation, mixing, trapezoid sums and extremes.
// Depends on dclgp_pkg; pushes each closed record into the queue.
module dclgp_front #(
    parameter int MAX_SAMPLES     = dclgp_pkg::MAX_SAMPLES_DEF,
    parameter int SINE_TABLE_BITS = dclgp_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          phase_step,
    input  logic [15:0]          span_min,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          ref_sample,
    input  logic [15:0]          dut_sample,
    input  logic                 last,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output dclgp_pkg::rec_t      rec
);
    import dclgp_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    fr_state_t state_reg, state_next;
    logic [31:0] phase_reg;
    logic [CW-1:0] cnt_reg;
    logic [4:0] step_reg;
    logic close_reg, flip_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg, b_reg;
    logic signed [35:0] x_reg, y_reg, z_reg;
    logic signed [15:0] s_reg, c_reg;
    logic signed [31:0] p_reg [4];
    logic signed [SUM_W-1:0] sum_reg [4];
    logic signed [31:0] prev_reg [4];
    logic signed [SAMPLE_BITS-1:0] ext_reg [4];
    logic have_reg;
    logic out_v_reg;
    rec_t out_reg;

    logic [31:0] ang, ang_rot;
    logic fire, close_now, flip_now, push_ok;
    logic signed [35:0] dx, dy, rx, ry, atan_s;
    logic signed [15:0] c_clamp, s_clamp;
    logic signed [SUM_W-1:0] sum_next [4];
    logic signed [SAMPLE_BITS-1:0] ext_next [4];
    logic signed [SAMPLE_BITS:0] span1, span2;

    assign in_ready  = state_reg == FR_IDLE;
    assign fire      = in_valid && in_ready;
    assign ang       = (phase_reg >> (32 - SINE_TABLE_BITS)) << (32 - SINE_TABLE_BITS);
    assign flip_now  = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
    assign ang_rot   = flip_now ? ang - 32'h8000_0000 : ang;
    assign close_now = last || (cnt_reg == CW'(MAX_SAMPLES - 1));
    assign push_ok   = !close_reg || !out_v_reg || rec_ready;
    assign rec_valid = out_v_reg;
    assign rec       = out_reg;
    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign atan_s    = $signed({4'd0, atan_turn(step_reg)});
    assign rx        = (x_reg + 36'sd128) >>> 8;
    assign ry        = (y_reg + 36'sd128) >>> 8;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: if (in_valid) state_next = FR_ROT;
            FR_ROT:  if (step_reg == 5'(ROT_STEPS - 1)) state_next = FR_MIX;
            FR_MIX:  state_next = FR_PROD;
            FR_PROD: state_next = FR_ACC;
            FR_ACC:  if (push_ok) state_next = FR_IDLE;
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        if (rx > 36'sd32767) c_clamp = 16'sd32767;
        else if (rx < -36'sd32767) c_clamp = -16'sd32767;
        else c_clamp = rx[15:0];
        if (ry > 36'sd32767) s_clamp = 16'sd32767;
        else if (ry < -36'sd32767) s_clamp = -16'sd32767;
        else s_clamp = ry[15:0];
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum_next[k] = have_reg ? sum_reg[k] + SUM_W'(prev_reg[k]) + SUM_W'(p_reg[k])
                                   : sum_reg[k];
        end
        if (have_reg) begin
            ext_next[0] = (a_reg < ext_reg[0]) ? a_reg : ext_reg[0];
            ext_next[1] = (a_reg > ext_reg[1]) ? a_reg : ext_reg[1];
            ext_next[2] = (b_reg < ext_reg[2]) ? b_reg : ext_reg[2];
            ext_next[3] = (b_reg > ext_reg[3]) ? b_reg : ext_reg[3];
        end else begin
            ext_next[0] = a_reg; ext_next[1] = a_reg;
            ext_next[2] = b_reg; ext_next[3] = b_reg;
        end
        span1 = (SAMPLE_BITS+1)'(ext_next[1]) - (SAMPLE_BITS+1)'(ext_next[0]);
        span2 = (SAMPLE_BITS+1)'(ext_next[3]) - (SAMPLE_BITS+1)'(ext_next[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            phase_reg <= '0;
            cnt_reg <= '0;
            have_reg <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                sum_reg[k] <= '0;
                prev_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (rec_ready) out_v_reg <= 1'b0;
            unique case (state_reg)
                FR_IDLE: begin
                    step_reg <= '0;
                    if (fire) begin
                        close_reg <= close_now;
                        a_reg <= ref_sample[SAMPLE_BITS-1:0];
                        b_reg <= dut_sample[SAMPLE_BITS-1:0];
                        flip_reg <= flip_now;
                        x_reg <= 36'(SINE_SEED);
                        y_reg <= '0;
                        z_reg <= {{4{ang_rot[31]}}, ang_rot};
                        if (close_now) begin
                            phase_reg <= '0;
                            cnt_reg <= '0;
                        end else begin
                            phase_reg <= phase_reg + phase_step;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                FR_ROT: begin
                    step_reg <= step_reg + 1'b1;
                    if (!z_reg[35]) begin
                        x_reg <= x_reg - dx; y_reg <= y_reg + dy; z_reg <= z_reg - atan_s;
                    end else begin
                        x_reg <= x_reg + dx; y_reg <= y_reg - dy; z_reg <= z_reg + atan_s;
                    end
                end
                FR_MIX: begin
                    s_reg <= flip_reg ? -s_clamp : s_clamp;
                    c_reg <= flip_reg ? -c_clamp : c_clamp;
                end
                FR_PROD: begin
                    p_reg[0] <= 32'(a_reg) * 32'(s_reg);
                    p_reg[1] <= 32'(a_reg) * 32'(c_reg);
                    p_reg[2] <= 32'(b_reg) * 32'(s_reg);
                    p_reg[3] <= 32'(b_reg) * 32'(c_reg);
                end
                FR_ACC: begin
                    if (push_ok) begin
                        if (close_reg) begin
                            out_v_reg <= 1'b1;
                            out_reg.s0 <= sum_next[0];
                            out_reg.s1 <= sum_next[1];
                            out_reg.s2 <= sum_next[2];
                            out_reg.s3 <= sum_next[3];
                            out_reg.span_low <= (span1 < $signed({1'b0, span_min}))
                                             || (span2 < $signed({1'b0, span_min}));
                            have_reg <= 1'b0;
                            for (int k = 0; k < 4; k++) begin
                                sum_reg[k] <= '0;
                                prev_reg[k] <= '0;
                            end
                        end else begin
                            have_reg <= 1'b1;
                            for (int k = 0; k < 4; k++) begin
                                sum_reg[k] <= sum_next[k];
                                prev_reg[k] <= p_reg[k];
                                ext_reg[k] <= ext_next[k];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

>>> src/dclgp_queue.sv
// Two-entry queue of closed records between the front and back parts.
// Depends on dclgp_pkg for the record type.
module dclgp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  dclgp_pkg::rec_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output dclgp_pkg::rec_t rd_data
);
    import dclgp_pkg::*;

    rec_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

>>> src/dclgp_back.sv
// Back part: CORDIC vectoring of both channels, ratio division, phase scaling.
// Depends on dclgp_pkg; one vectoring step and one quotient bit per cycle.
module dclgp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rec_valid,
    output logic            rec_ready,
    input  dclgp_pkg::rec_t rec,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [31:0]     gain,
    output logic [15:0]     phase_deg,
    output logic [1:0]      status
);
    import dclgp_pkg::*;

    localparam int VW = SUM_W + 3;

    bk_state_t state_reg, state_next;
    logic signed [VW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [31:0] z1_reg, z2_reg;
    logic zero1_reg, zero2_reg, span_reg;
    logic [5:0] step_reg;
    logic [VW-1:0] num_reg, den_reg, rem_reg;
    logic [31:0] q_reg;
    logic sat_reg;
    logic [31:0] gain_reg;
    logic [15:0] deg_reg;
    logic [1:0] st_reg;

    logic signed [VW-1:0] sx1, sy1, sx2, sy2;
    logic signed [63:0] prod;
    logic [31:0] d;
    logic [VW:0] r2;

    assign rec_ready = state_reg == BK_IDLE;
    assign m_valid   = state_reg == BK_OUT;
    assign gain      = gain_reg;
    assign phase_deg = deg_reg;
    assign status    = st_reg;

    always_comb begin
        sx1 = VW'($signed(rec.s0));
        sy1 = VW'($signed(rec.s1));
        sx2 = VW'($signed(rec.s2));
        sy2 = VW'($signed(rec.s3));
        d = z2_reg - z1_reg;
        prod = 64'($signed(d)) * 64'sd46080 + 64'sh8000_0000;
        r2 = {rem_reg, num_reg[VW-1]};
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (rec_valid) state_next = BK_VEC;
            BK_VEC:  if (step_reg == 6'(VEC_STEPS - 1)) state_next = BK_DIV;
            BK_DIV:  state_next = BK_FRAC;
            BK_FRAC: if (step_reg == 6'd32 || sat_reg) state_next = BK_OUT;
            BK_OUT:  if (m_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
        unique case (state_reg)
            BK_IDLE: begin
                step_reg <= '0;
                span_reg <= rec.span_low;
                zero1_reg <= (sx1 == '0) && (sy1 == '0);
                zero2_reg <= (sx2 == '0) && (sy2 == '0);
                x1_reg <= sx1[VW-1] ? -sx1 : sx1;
                y1_reg <= sx1[VW-1] ? -sy1 : sy1;
                z1_reg <= sx1[VW-1] ? 32'h8000_0000 : 32'h0;
                x2_reg <= sx2[VW-1] ? -sx2 : sx2;
                y2_reg <= sx2[VW-1] ? -sy2 : sy2;
                z2_reg <= sx2[VW-1] ? 32'h8000_0000 : 32'h0;
            end
            BK_VEC: begin
                step_reg <= step_reg + 1'b1;
                if (!y1_reg[VW-1]) begin
                    x1_reg <= x1_reg + (y1_reg >>> step_reg);
                    y1_reg <= y1_reg - (x1_reg >>> step_reg);
                    z1_reg <= z1_reg + atan_turn(step_reg[4:0]);
                end else begin
                    x1_reg <= x1_reg - (y1_reg >>> step_reg);
                    y1_reg <= y1_reg + (x1_reg >>> step_reg);
                    z1_reg <= z1_reg - atan_turn(step_reg[4:0]);
                end
                if (!y2_reg[VW-1]) begin
                    x2_reg <= x2_reg + (y2_reg >>> step_reg);
                    y2_reg <= y2_reg - (x2_reg >>> step_reg);
                    z2_reg <= z2_reg + atan_turn(step_reg[4:0]);
                end else begin
                    x2_reg <= x2_reg - (y2_reg >>> step_reg);
                    y2_reg <= y2_reg + (x2_reg >>> step_reg);
                    z2_reg <= z2_reg - atan_turn(step_reg[4:0]);
                end
            end
            BK_DIV: begin
                step_reg <= '0;
                num_reg <= (zero2_reg || x2_reg[VW-1]) ? '0 : x2_reg;
                den_reg <= (zero1_reg || x1_reg[VW-1]) ? '0 : x1_reg;
                if (zero1_reg) z1_reg <= '0;
                if (zero2_reg) z2_reg <= '0;
                rem_reg <= '0;
                q_reg <= '0;
                sat_reg <= zero1_reg || x1_reg[VW-1] || x1_reg == '0;
            end
            BK_FRAC: begin
                // The quotient of num * 2^16 by den takes 32 bits, one per cycle,
                // with the numerator bits shifted in from the top.
                if (step_reg == 6'd0) begin
                    // Integer quotient must fit 16 bits: num < den << 16.
                    if ({16'd0, num_reg} >= {den_reg, 16'd0}) sat_reg <= 1'b1;
                    rem_reg <= num_reg >> 16;
                    num_reg <= num_reg << (VW - 16);
                    step_reg <= 6'd1;
                    q_reg <= '0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                    num_reg <= num_reg << 1;
                    if (r2 >= {1'b0, den_reg}) begin
                        rem_reg <= VW'(r2 - {1'b0, den_reg});
                        q_reg <= {q_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= r2[VW-1:0];
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                end
                deg_reg <= prod[47:32];
                st_reg <= zero1_reg || sat_reg && den_reg == '0 ? ST_ZERO
                        : (span_reg ? ST_SPAN : ST_OK);
                if (sat_reg) gain_reg <= 32'hFFFF_FFFF;
            end
            BK_OUT: begin
            end
            default: begin
            end
        endcase
        if (state_reg == BK_FRAC && state_next == BK_OUT && !sat_reg) begin
            gain_reg <= (r2 >= {1'b0, den_reg}) ? {q_reg[30:0], 1'b1}
                                                  : {q_reg[30:0], 1'b0};
        end
    end
endmodule

>>> src/dual_channel_lock_in_gain_phase.sv
// Two-channel lock-in gain/phase meter, top level.
// Each sample pair passes in the front part through 20 CORDIC rotation steps
// for the reference, a rounding state, a product state and an accumulate state,
// and s_tready stays low meanwhile. Each closed record then passes in the
// back part through 24 vectoring steps, a setup state and a restoring division
// before its result can be taken. A two-record queue in between lets the front
// part go on; it stalls only when a closing pair finds the queue full.
module dual_channel_lock_in_gain_phase #(
    parameter int MAX_SAMPLES     = dclgp_pkg::MAX_SAMPLES_DEF,
    parameter int SINE_TABLE_BITS = dclgp_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // ref_sample [15:0], dut_sample [31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // gain [31:0], phase_deg [47:32], status [49:48]
);
    import dclgp_pkg::*;

    logic [31:0] step_reg;
    logic [15:0] thr_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    rec_t fq_rec, qb_rec;
    logic [31:0] gain;
    logic [15:0] phase_deg;
    logic [1:0] status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            thr_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PHASE_STEP: step_reg <= cfg_data;
                CFG_THRESHOLD:  thr_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    dclgp_front #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .phase_step(step_reg), .span_min(thr_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .ref_sample(s_tdata[15:0]), .dut_sample(s_tdata[31:16]), .last(s_tlast),
        .rec_valid(fq_valid), .rec_ready(fq_ready), .rec(fq_rec)
    );

    dclgp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_rec),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_rec)
    );

    dclgp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .rec_valid(qb_valid), .rec_ready(qb_ready), .rec(qb_rec),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .gain(gain), .phase_deg(phase_deg), .status(status)
    );

    assign m_tdata = {6'd0, status, phase_deg, gain};
endmodule

>>> test/dual_channel_lock_in_gain_phase_tb.sv
// Self-checking testbench for the two-channel lock-in gain/phase meter.
// A local predictor tracks every accepted sample pair and checks each closed-record result.
// Depends on dclgp_pkg and dual_channel_lock_in_gain_phase.
`timescale 1ns / 1ps

module dual_channel_lock_in_gain_phase_tb;
    import dclgp_pkg::*;

    typedef struct {
        logic signed [15:0] ch1;
        logic signed [15:0] ch2;
        logic               closes;
    } sample_pair_t;

    typedef struct {
        logic [31:0] gain;
        logic [15:0] phase;
        logic [1:0]  st;
    } meter_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_PHASE_STEP;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    sample_pair_t  pairs_to_send[$];
    meter_result_t results_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int records_closed = 0;
    int results_seen = 0;
    int pairs_accepted = 0;
    int cycle_count = 0;
    int hold_left = 0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;

    // Predictor state.
    logic [31:0] step_reg = '0;
    logic [15:0] span_min_reg = '0;
    logic [31:0] ref_acc = '0;
    longint      mix_sum[4];
    longint      mix_prev[4];
    longint      span[4];
    bit          record_open = 0;
    int          record_len = 0;

    dual_channel_lock_in_gain_phase u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint wrap48(longint v);
        logic [63:0] u;
        u = v;
        return longint'({{16{u[47]}}, u[47:0]});
    endfunction

    function automatic logic [31:0] atan_step(int i);
        logic [31:0] t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return t[i];
    endfunction

    function automatic void ref_wave(input logic [31:0] ang_in, output longint s,
                                     output longint c);
        logic [31:0] ang;
        bit          flip;
        longint      x, y, z, dx, dy;
        ang = ang_in;
        flip = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
        if (flip) ang = ang - 32'h8000_0000;
        x = 5093851;
        y = 0;
        z = longint'($signed(ang));
        for (int i = 0; i < 20; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_step(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_step(i));
            end
        end
        x = shr(x + 128, 8);
        y = shr(y + 128, 8);
        if (x > 32767) x = 32767;
        if (x < -32767) x = -32767;
        if (y > 32767) y = 32767;
        if (y < -32767) y = -32767;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void polar(input longint xi, input longint yi,
                                  output longint unsigned mag, output logic [31:0] ang);
        longint x, y, dx, dy;
        x = xi;
        y = yi;
        ang = '0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return;
        end
        if (x < 0) begin
            x = -x; y = -y; ang = 32'h8000_0000;
        end
        for (int i = 0; i < 24; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; ang += atan_step(i);
            end else begin
                x -= dx; y += dy; ang -= atan_step(i);
            end
        end
        mag = (x > 0) ? longint'(x) : 0;
    endfunction

    function automatic logic [31:0] gain_q16(longint unsigned num, longint unsigned den);
        longint unsigned q, r;
        if (den == 0) return 32'hFFFF_FFFF;
        q = num / den;
        r = num % den;
        if (q > 64'hFFFF) return 32'hFFFF_FFFF;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r -= den; q |= 1;
            end
        end
        return q[31:0];
    endfunction

    task automatic track_pair(sample_pair_t sp);
        longint        a, b, s, c, p[4], zs, deg;
        longint unsigned m1, m2;
        logic [31:0]   a1, a2, d;
        meter_result_t r;
        a = sp.ch1;
        b = sp.ch2;
        ref_wave({ref_acc[31:22], 22'd0}, s, c);
        p[0] = a * s; p[1] = a * c; p[2] = b * s; p[3] = b * c;
        if (record_open) begin
            for (int k = 0; k < 4; k++) mix_sum[k] = wrap48(mix_sum[k] + mix_prev[k] + p[k]);
            if (a < span[0]) span[0] = a;
            if (a > span[1]) span[1] = a;
            if (b < span[2]) span[2] = b;
            if (b > span[3]) span[3] = b;
        end else begin
            span[0] = a; span[1] = a; span[2] = b; span[3] = b;
            record_open = 1;
        end
        for (int k = 0; k < 4; k++) mix_prev[k] = p[k];
        ref_acc += step_reg;
        record_len++;
        if (!sp.closes && record_len < MAX_SAMPLES_DEF) return;
        polar(mix_sum[0], mix_sum[1], m1, a1);
        polar(mix_sum[2], mix_sum[3], m2, a2);
        d = a2 - a1;
        zs = longint'($signed(d));
        deg = (zs * DEG128_PER_TURN + 64'sh8000_0000) >>> 32;
        if (m1 == 0) r.st = ST_ZERO;
        else if (span[1] - span[0] < longint'(span_min_reg) ||
                 span[3] - span[2] < longint'(span_min_reg)) r.st = ST_SPAN;
        else r.st = ST_OK;
        r.gain = gain_q16(m2, m1);
        r.phase = deg[15:0];
        results_due.push_back(r);
        records_closed++;
        ref_acc = '0;
        for (int k = 0; k < 4; k++) begin
            mix_sum[k] = 0; mix_prev[k] = 0; span[k] = 0;
        end
        record_open = 0;
        record_len = 0;
    endtask

    always @(posedge aclk) begin
        sample_pair_t sp;
        if (s_tvalid && s_tready) begin
            sp.ch1 = s_tdata[15:0];
            sp.ch2 = s_tdata[31:16];
            sp.closes = s_tlast;
            track_pair(sp);
            pairs_accepted++;
        end
        if (aresetn && (!s_tvalid || s_tready)) begin
            if (pairs_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                sp = pairs_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {sp.ch2, sp.ch1};
                s_tlast <= sp.closes;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        meter_result_t e;
        if (hold_request && !hold_done) begin
            hold_left <= 3000;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (m_tvalid && m_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                e = results_due.pop_front();
                if (m_tdata[31:0] !== e.gain) begin
                    $display("%0t: gain mismatch, expected %h actual %h",
                             $time, e.gain, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[47:32] !== e.phase) begin
                    $display("%0t: phase mismatch, expected %0d actual %0d", $time,
                             $signed(e.phase), $signed(m_tdata[47:32]));
                    error_count++;
                end
                if (m_tdata[49:48] !== e.st) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, e.st, m_tdata[49:48]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_pair(int a, int b, bit closes);
        sample_pair_t sp;
        sp.ch1 = 16'(a);
        sp.ch2 = 16'(b);
        sp.closes = closes;
        pairs_to_send.push_back(sp);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_PHASE_STEP) step_reg = val;
        else span_min_reg = val[15:0];
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pairs_to_send.size() > 0 || s_tvalid || results_due.size() > 0);
        repeat (100) @(posedge aclk);
    endtask

    // One record of random shape: full-scale or scaled noise, a flat or near-flat channel, or a silent one.
    task automatic add_record(int len);
        int kind, amp1, amp2, off;
        kind = $urandom_range(9);
        amp1 = $urandom_range(32767);
        amp2 = $urandom_range(32767);
        off = $urandom_range(200) - 100;
        for (int i = 0; i < len; i++) begin
            int a, b;
            a = $urandom_range(65535) - 32768;
            b = $urandom_range(65535) - 32768;
            if (kind < 4) begin
                a = (a * amp1) / 32768;
                b = (b * amp2) / 32768;
            end else if (kind == 4) begin
                a = 0;
            end else if (kind == 5) begin
                b = off;
            end else if (kind == 6) begin
                a = off + $urandom_range(3);
            end
            add_pair(a, b, i == len - 1);
        end
    endtask

    task automatic random_phase(int n_pairs, int idle, int stall);
        int sent;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < n_pairs) begin
            int len;
            len = ($urandom_range(19) == 0) ? $urandom_range(200, 60) :
                  ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 2);
            add_record(len);
            sent += len;
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, one-item record, silent channel one, flat channel two.
        write_reg(CFG_PHASE_STEP, 32'h1000_0000);
        write_reg(CFG_THRESHOLD, 16'd0);
        add_pair(-32768, 32767, 1);
        add_pair(32767, -32768, 0);
        add_pair(-32768, 32767, 0);
        add_pair(32767, -32768, 0);
        add_pair(-32768, 32767, 1);
        add_pair(0, 12345, 0);
        add_pair(0, -32768, 0);
        add_pair(0, 32767, 1);
        add_pair(20000, 5, 0);
        add_pair(-20000, 5, 0);
        add_pair(15000, 5, 0);
        add_pair(-1, 5, 1);
        add_pair(-21846, 21845, 0);
        add_pair(21845, -21846, 0);
        add_pair(1, -1, 0);
        add_pair(0, 0, 1);
        drain();
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        add_pair(-32768, -32768, 0);
        add_pair(32767, 32767, 0);
        add_pair(100, -100, 1);
        add_pair(5, 5, 0);
        add_pair(-5, 0, 1);
        drain();

        write_reg(CFG_PHASE_STEP, $urandom);
        write_reg(CFG_THRESHOLD, 16'd0);
        random_phase(400, 0, 0);
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_THRESHOLD, $urandom_range(65535));
        random_phase(400, 62, 0);
        write_reg(CFG_PHASE_STEP, 32'd0);
        write_reg(CFG_THRESHOLD, $urandom_range(2000));
        random_phase(400, 0, 62);
        write_reg(CFG_PHASE_STEP, $urandom);
        write_reg(CFG_THRESHOLD, $urandom_range(500));
        random_phase(400, 37, 37);

        // Receiver holds off for a long stretch while the sender keeps offering.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 40; i++) add_record($urandom_range(3, 1));
        @(posedge aclk);
        hold_request <= 1'b1;
        drain();

        // Sender waits for every result before sending the next record.
        write_reg(CFG_PHASE_STEP, $urandom_range(32'h0800_0000));
        for (int i = 0; i < 12; i++) begin
            add_record($urandom_range(30, 2));
            drain();
        end

        $display("Covered %0d sample pairs in %0d records, %0d results checked,",
                 pairs_accepted, records_closed, results_seen);
        $display("with several register settings, idle and stall mixes, and a long hold-off.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
src/dclgp_pkg.sv
src/dclgp_front.sv
src/dclgp_queue.sv
src/dclgp_back.sv
src/dual_channel_lock_in_gain_phase.sv
test/dual_channel_lock_in_gain_phase_tb.sv
